// ===== src/tat_pkg.sv =====
// ----------------------------------------------------------------------------
// tat_pkg
// Shared widths, register indexes, tile modes and reset values for the
// texture address tiling block.
// ----------------------------------------------------------------------------
package tat_pkg;

    // Field widths of the pixel and texel words
    localparam int PIX_W  = 15;
    localparam int TEX_W  = 12;

    // Matrix coefficients and the mapped sum
    localparam int COEF_W = 32;
    localparam int PROD_W = COEF_W + PIX_W + 2;
    localparam int ACC_W  = PROD_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MODE_W     = 2;
    localparam int DIMS_W     = 29;
    localparam int WIDTH_FW   = 16;
    localparam int HEIGHT_FW  = 13;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_M_XX        = 3'd0,
        REG_M_XY        = 3'd1,
        REG_M_XT        = 3'd2,
        REG_M_YX        = 3'd3,
        REG_M_YY        = 3'd4,
        REG_M_YT        = 3'd5,
        REG_TILE_MODE   = 3'd6,
        REG_BITMAP_DIMS = 3'd7
    } cfg_reg_t;

    // Tile modes; the unused code behaves as clamp
    typedef enum logic [MODE_W-1:0] {
        TILE_CLAMP  = 2'd0,
        TILE_REPEAT = 2'd1,
        TILE_MIRROR = 2'd2
    } tile_mode_t;

    // Reset values: identity matrix, clamp, 1 x 1 bitmap
    localparam logic [COEF_W-1:0] COEF_ONE_RST  = 32'h0001_0000;
    localparam logic [COEF_W-1:0] COEF_ZERO_RST = 32'h0000_0000;
    localparam logic [DIMS_W-1:0] DIMS_RST      = 29'h0001_0001;

endpackage

// ===== src/tat_pixel_if.sv =====
// ----------------------------------------------------------------------------
// tat_pixel_if
// Pixel word channel: device pixel position and end-of-span flag.
// ----------------------------------------------------------------------------
interface tat_pixel_if
    import tat_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] dev_x;
    logic [PIX_W-1:0] dev_y;
    logic             row_end;

    modport source (output valid, output dev_x, output dev_y, output row_end, input ready);
    modport sink   (input valid, input dev_x, input dev_y, input row_end, output ready);
endinterface

// ===== src/tat_texel_if.sv =====
// ----------------------------------------------------------------------------
// tat_texel_if
// Texel word channel: folded bitmap coordinates and end-of-span flag.
// ----------------------------------------------------------------------------
interface tat_texel_if
    import tat_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [TEX_W-1:0] texel_x;
    logic [TEX_W-1:0] texel_y;
    logic             span_last;

    modport source (output valid, output texel_x, output texel_y, output span_last,
                    input ready);
    modport sink   (input valid, input texel_x, input texel_y, input span_last,
                    output ready);
endinterface

// ===== src/texture_address_tiling_core.sv =====
// Throughput: one word per cycle; every stage holds under back-pressure and
// fills its own bubble, so the pixel side stalls only when all stages are full.
// Depth is set by the remainder pipeline, which retires four bits per stage.
// Reset clears all valid bits and loads the identity matrix, clamp mode and
// a 1 x 1 bitmap; payload registers are not reset.
// ----------------------------------------------------------------------------
// texture_address_tiling_core
// Maps each device pixel centre through an inverse affine matrix, floors the
// result and folds it into the bitmap by clamp, repeat or mirror tiling.
// ----------------------------------------------------------------------------
module texture_address_tiling_core
    import tat_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int MAX_DIM   = 4096
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    tat_pixel_if.sink             pixel,
    tat_texel_if.source           texel
);

    localparam int SHIFT = FRAC_BITS + 1;
    localparam int S_W   = ACC_W - SHIFT;
    localparam int U_W   = S_W - 1;
    localparam int STEPS = 4;
    localparam int N_DIV = (U_W + STEPS - 1) / STEPS;
    localparam int U_PAD = N_DIV * STEPS;
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int MW    = DIM_W + 1;
    localparam int LIM_W = WIDTH_FW + 1;

    typedef struct packed {
        logic [U_PAD-1:0] ux;
        logic [U_PAD-1:0] uy;
        logic [MW-1:0]    rx;
        logic [MW-1:0]    ry;
        logic             neg_x;
        logic             neg_y;
        logic [DIM_W-1:0] cx;
        logic [DIM_W-1:0] cy;
        logic             last;
    } div_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [COEF_W-1:0] m_xx_reg, m_xy_reg, m_xt_reg;
    logic signed [COEF_W-1:0] m_yx_reg, m_yy_reg, m_yt_reg;
    logic [MODE_W-1:0]        tile_mode_reg;
    logic [DIMS_W-1:0]        bitmap_dims_reg;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_xx_reg        <= COEF_ONE_RST;
            m_xy_reg        <= COEF_ZERO_RST;
            m_xt_reg        <= COEF_ZERO_RST;
            m_yx_reg        <= COEF_ZERO_RST;
            m_yy_reg        <= COEF_ONE_RST;
            m_yt_reg        <= COEF_ZERO_RST;
            tile_mode_reg   <= TILE_CLAMP;
            bitmap_dims_reg <= DIMS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_M_XX:        m_xx_reg        <= cfg_data;
                REG_M_XY:        m_xy_reg        <= cfg_data;
                REG_M_XT:        m_xt_reg        <= cfg_data;
                REG_M_YX:        m_yx_reg        <= cfg_data;
                REG_M_YY:        m_yy_reg        <= cfg_data;
                REG_M_YT:        m_yt_reg        <= cfg_data;
                REG_TILE_MODE:   tile_mode_reg   <= cfg_data[MODE_W-1:0];
                REG_BITMAP_DIMS: bitmap_dims_reg <= cfg_data[DIMS_W-1:0];
            endcase
        end
    end

    // Limit the bitmap size to 1..MAX_DIM and form the fold modulus
    logic [LIM_W-1:0] w_raw, h_raw;
    logic [DIM_W-1:0] w_lim, h_lim;
    logic [MW-1:0]    mod_x, mod_y;

    always_comb
    begin
        w_raw = LIM_W'(bitmap_dims_reg[WIDTH_FW-1:0]);
        h_raw = LIM_W'(bitmap_dims_reg[WIDTH_FW +: HEIGHT_FW]);
        if (w_raw == '0)
            w_lim = DIM_W'(1);
        else if (w_raw > LIM_W'(MAX_DIM))
            w_lim = DIM_W'(MAX_DIM);
        else
            w_lim = w_raw[DIM_W-1:0];
        if (h_raw == '0)
            h_lim = DIM_W'(1);
        else if (h_raw > LIM_W'(MAX_DIM))
            h_lim = DIM_W'(MAX_DIM);
        else
            h_lim = h_raw[DIM_W-1:0];
        if (tile_mode_reg == TILE_MIRROR)
        begin
            mod_x = {w_lim, 1'b0};
            mod_y = {h_lim, 1'b0};
        end
        else
        begin
            mod_x = {1'b0, w_lim};
            mod_y = {1'b0, h_lim};
        end
    end

    // One restoring remainder step: shift in a bit, subtract if it fits
    function automatic logic [MW-1:0] rem_step(input logic [MW-1:0] r,
                                               input logic [MW-1:0] m,
                                               input logic          b);
        logic [MW:0] t;
        t = {r, b};
        if (t >= {1'b0, m})
            t = t - {1'b0, m};
        return t[MW-1:0];
    endfunction

    // Fold one axis from its remainder and clamp value
    function automatic logic [DIM_W-1:0] fold_axis(input logic [MW-1:0]    r,
                                                   input logic [MW-1:0]    m,
                                                   input logic [DIM_W-1:0] size,
                                                   input logic [DIM_W-1:0] clampv,
                                                   input logic             neg,
                                                   input logic [MODE_W-1:0] mode);
        logic [MW-1:0]    fm;
        logic [MW-1:0]    mir;
        logic [DIM_W-1:0] res;
        // Negative values were taken as their complement: reflect the remainder
        fm  = neg ? (m - MW'(1) - r) : r;
        mir = (fm >= {1'b0, size}) ? (m - MW'(1) - fm) : fm;
        unique case (mode)
            TILE_REPEAT: res = fm[DIM_W-1:0];
            TILE_MIRROR: res = mir[DIM_W-1:0];
            default:     res = clampv;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stage enables: each stage advances when empty or when the next moves
    // ------------------------------------------------------------------
    logic             v1_reg, v2_reg, out_valid_reg;
    logic [N_DIV:0]   dv_reg;
    logic [N_DIV:0]   en_d;
    logic             en1, en2, en_out;

    assign en_out        = !out_valid_reg || texel.ready;
    assign en_d[N_DIV]   = !dv_reg[N_DIV] || en_out;
    assign en2           = !v2_reg || en_d[0];
    assign en1           = !v1_reg || en2;
    assign pixel.ready   = en1;

    for (genvar k = 0; k < N_DIV; k++)
    begin : g_en
        assign en_d[k] = !dv_reg[k] || en_d[k+1];
    end

    // ------------------------------------------------------------------
    // Stage 1: matrix products on the doubled pixel centre
    // ------------------------------------------------------------------
    logic signed [PIX_W+1:0]  px2, py2;
    logic signed [PROD_W-1:0] p_xx_next, p_xy_next, p_yx_next, p_yy_next;
    logic signed [PROD_W-1:0] p_xx_reg, p_xy_reg, p_yx_reg, p_yy_reg;
    logic                     last1_reg;

    always_comb
    begin
        px2       = {1'b0, pixel.dev_x, 1'b1};
        py2       = {1'b0, pixel.dev_y, 1'b1};
        p_xx_next = m_xx_reg * px2;
        p_xy_next = m_xy_reg * py2;
        p_yx_next = m_yx_reg * px2;
        p_yy_next = m_yy_reg * py2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en1)
            v1_reg <= pixel.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            p_xx_reg  <= p_xx_next;
            p_xy_reg  <= p_xy_next;
            p_yx_reg  <= p_yx_next;
            p_yy_reg  <= p_yy_next;
            last1_reg <= pixel.row_end;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: sum products and doubled translation
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] acc_x_next, acc_y_next;
    logic signed [ACC_W-1:0] acc_x_reg, acc_y_reg;
    logic                    last2_reg;

    always_comb
    begin
        acc_x_next = {p_xx_reg[PROD_W-1], p_xx_reg} + {p_xy_reg[PROD_W-1], p_xy_reg}
                   + {{(ACC_W-COEF_W-1){m_xt_reg[COEF_W-1]}}, m_xt_reg, 1'b0};
        acc_y_next = {p_yx_reg[PROD_W-1], p_yx_reg} + {p_yy_reg[PROD_W-1], p_yy_reg}
                   + {{(ACC_W-COEF_W-1){m_yt_reg[COEF_W-1]}}, m_yt_reg, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en2)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            acc_x_reg <= acc_x_next;
            acc_y_reg <= acc_y_next;
            last2_reg <= last1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: floor, split sign from magnitude, resolve clamp
    // ------------------------------------------------------------------
    div_t d_reg  [0:N_DIV];
    div_t d_next [0:N_DIV];

    logic signed [ACC_W-1:0] sh_x, sh_y;
    logic [S_W-1:0]          sx, sy;
    logic [U_W-1:0]          mag_x, mag_y;

    always_comb
    begin
        sh_x = acc_x_reg >>> SHIFT;
        sh_y = acc_y_reg >>> SHIFT;
        sx   = sh_x[S_W-1:0];
        sy   = sh_y[S_W-1:0];
        // Negative values go in as their complement so the remainder stays unsigned
        mag_x = sx[S_W-1] ? ~sx[U_W-1:0] : sx[U_W-1:0];
        mag_y = sy[S_W-1] ? ~sy[U_W-1:0] : sy[U_W-1:0];

        d_next[0].ux    = U_PAD'(mag_x);
        d_next[0].uy    = U_PAD'(mag_y);
        d_next[0].rx    = '0;
        d_next[0].ry    = '0;
        d_next[0].neg_x = sx[S_W-1];
        d_next[0].neg_y = sy[S_W-1];
        d_next[0].last  = last2_reg;

        if (sx[S_W-1])
            d_next[0].cx = '0;
        else if (sx[U_W-1:0] > U_W'(w_lim - DIM_W'(1)))
            d_next[0].cx = w_lim - DIM_W'(1);
        else
            d_next[0].cx = sx[DIM_W-1:0];

        if (sy[S_W-1])
            d_next[0].cy = '0;
        else if (sy[U_W-1:0] > U_W'(h_lim - DIM_W'(1)))
            d_next[0].cy = h_lim - DIM_W'(1);
        else
            d_next[0].cy = sy[DIM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg[0] <= 1'b0;
        else if (en_d[0])
            dv_reg[0] <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_d[0])
            d_reg[0] <= d_next[0];
    end

    // ------------------------------------------------------------------
    // Remainder stages: retire STEPS magnitude bits per stage, both axes
    // ------------------------------------------------------------------
    for (genvar k = 0; k < N_DIV; k++)
    begin : g_div
        always_comb
        begin
            div_t cur;
            cur = d_reg[k];
            for (int s = 0; s < STEPS; s++)
            begin
                cur.rx = rem_step(cur.rx, mod_x, cur.ux[U_PAD-1]);
                cur.ry = rem_step(cur.ry, mod_y, cur.uy[U_PAD-1]);
                cur.ux = {cur.ux[U_PAD-2:0], 1'b0};
                cur.uy = {cur.uy[U_PAD-2:0], 1'b0};
            end
            d_next[k+1] = cur;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[k+1] <= 1'b0;
            else if (en_d[k+1])
                dv_reg[k+1] <= dv_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en_d[k+1])
                d_reg[k+1] <= d_next[k+1];
        end
    end

    // ------------------------------------------------------------------
    // Output stage: fold by tile mode and hold the texel word
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] tx_next, ty_next;
    logic [DIM_W-1:0] tx_reg, ty_reg;
    logic             last_reg;

    always_comb
    begin
        tx_next = fold_axis(d_reg[N_DIV].rx, mod_x, w_lim, d_reg[N_DIV].cx,
                            d_reg[N_DIV].neg_x, tile_mode_reg);
        ty_next = fold_axis(d_reg[N_DIV].ry, mod_y, h_lim, d_reg[N_DIV].cy,
                            d_reg[N_DIV].neg_y, tile_mode_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en_out)
            out_valid_reg <= dv_reg[N_DIV];
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            tx_reg   <= tx_next;
            ty_reg   <= ty_next;
            last_reg <= d_reg[N_DIV].last;
        end
    end

    assign texel.valid     = out_valid_reg;
    assign texel.texel_x   = TEX_W'(tx_reg);
    assign texel.texel_y   = TEX_W'(ty_reg);
    assign texel.span_last = last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The pixel side stalls only when every stage holds a word
    assert property (@(posedge clk) disable iff (!rst_n)
        !pixel.ready |-> (v1_reg && v2_reg && (&dv_reg) && out_valid_reg))
        else $error("pixel side stalled with a free stage");

    // An accepted pixel occupies the first stage next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready) |=> v1_reg)
        else $error("accepted pixel lost at the product stage");

    // A new texel word comes only from a filled last remainder stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(texel.valid) |-> $past(dv_reg[N_DIV]))
        else $error("texel word appeared without a source");

    // A word in the sum stage moves on when the next stage is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && en_d[0]) |=> dv_reg[0])
        else $error("word dropped between sum and floor stages");

endmodule
